### rtl/rmth_pkg.sv
// Shared types, constants and compare helper for the running median unit.
package rmth_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 32;

   typedef enum logic [1:0] {
      HOP_NONE,
      HOP_PUSH,
      HOP_REPLACE
   } heap_op_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_UP_RD,
      HS_UP_CMP,
      HS_DN_RDL,
      HS_DN_RDR,
      HS_DN_CMP
   } heap_state_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_WAIT,
      TS_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      MSEL_HOLD,
      MSEL_LOWER,
      MSEL_UPPER,
      MSEL_MEAN
   } median_sel_type;

   typedef struct packed {
      logic        start;
      logic        flush;
      logic        max_mode;
      heap_op_type op;
   } heap_cmd_type;

   // True if a belongs nearer the root than b
   function automatic logic above(input logic max_mode,
                                  input logic signed [SAMPLE_W-1:0] a,
                                  input logic signed [SAMPLE_W-1:0] b);
      above = max_mode ? (a > b) : (a < b);
   endfunction

endpackage

### rtl/running_median_two_heaps_unit.sv
// Running median over a sample stream, held in a lower max-heap and an upper min-heap.
//
// Each req_ transfer carries one signed 32-bit sample; tuser high empties both heaps
// first. One rsp_ transfer follows with the median, the held count and a drop flag.
// Items are handled one at a time: a push sifts up and a top replacement sifts down,
// walking at most log2(CAPACITY/2+1) heap levels; both heaps sift in parallel, each
// over its own single-port memory with a registered read, so the unit waits for the
// slower heap. A full store skips the heaps and drops the sample; its response is
// registered from the done state, with the drop flag set.
module running_median_two_heaps_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample [31:0]
   input  logic [rmth_pkg::SAMPLE_W-1:0]         req_tdata,
   // first [0]
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // median [31:0], count above it, zero fill to whole bytes
   output logic [((rmth_pkg::MEDIAN_W+$clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata,
   // dropped [0]
   output logic                                  rsp_tuser
);

   localparam int DEPTH  = CAPACITY / 2 + 1;
   localparam int S_W    = $clog2(DEPTH + 1);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W = ((rmth_pkg::MEDIAN_W + CNT_W + 7) / 8) * 8;
   localparam int SW     = rmth_pkg::SAMPLE_W;

   rmth_pkg::top_state_type    state_ff, state_in;
   rmth_pkg::median_sel_type   sel_ff, sel_in;
   logic                       drop_ff, drop_in;
   logic signed [SW-1:0]       med_ff, med_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                       rsp_drop_ff, rsp_drop_in;

   rmth_pkg::heap_cmd_type     lo_cmd, up_cmd;
   logic signed [SW-1:0]       lo_val, up_val, lo_top, up_top;
   logic                       lo_busy, up_busy;
   logic [S_W-1:0]             lo_size, up_size, lsz_e, usz_e;

   logic                       accept, slot_free, full;
   logic signed [SW-1:0]       x;
   logic [CNT_W-1:0]           count_e, count_now;
   logic signed [SW:0]         sum, sum_adj;
   logic signed [SW-1:0]       mean, med_pick;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign x         = req_tdata;
   assign lsz_e     = req_tuser ? '0 : lo_size;
   assign usz_e     = req_tuser ? '0 : up_size;
   assign count_e   = CNT_W'(lsz_e) + CNT_W'(usz_e);
   assign full      = count_e >= CNT_W'(CAPACITY);
   assign count_now = CNT_W'(lo_size) + CNT_W'(up_size);

   // Mean of the tops, one bit wider, truncated toward zero
   assign sum     = {lo_top[SW-1], lo_top} + {up_top[SW-1], up_top};
   assign sum_adj = sum + {{SW{1'b0}}, sum[SW]};
   assign mean    = sum_adj[SW:1];

   // Pick the median source
   always_comb begin
      unique case (sel_ff)
         rmth_pkg::MSEL_LOWER: med_pick = lo_top;
         rmth_pkg::MSEL_UPPER: med_pick = up_top;
         rmth_pkg::MSEL_MEAN:  med_pick = mean;
         default:              med_pick = med_ff;
      endcase
   end

   // Route the sample to the heaps
   always_comb begin
      lo_cmd   = '{start: accept, flush: req_tuser, max_mode: 1'b1, op: rmth_pkg::HOP_NONE};
      up_cmd   = '{start: accept, flush: req_tuser, max_mode: 1'b0, op: rmth_pkg::HOP_NONE};
      lo_val   = x;
      up_val   = x;
      sel_in   = rmth_pkg::MSEL_HOLD;
      priority if (full) begin
         sel_in = rmth_pkg::MSEL_HOLD;
      end else if (count_e == '0) begin
         lo_cmd.op = rmth_pkg::HOP_PUSH;
         sel_in    = rmth_pkg::MSEL_LOWER;
      end else if (lsz_e > usz_e) begin
         sel_in    = rmth_pkg::MSEL_MEAN;
         up_cmd.op = rmth_pkg::HOP_PUSH;
         if (x < med_ff) begin
            up_val    = lo_top;
            lo_cmd.op = rmth_pkg::HOP_REPLACE;
         end
      end else if (lsz_e == usz_e) begin
         if (x < med_ff) begin
            lo_cmd.op = rmth_pkg::HOP_PUSH;
            sel_in    = rmth_pkg::MSEL_LOWER;
         end else begin
            up_cmd.op = rmth_pkg::HOP_PUSH;
            sel_in    = rmth_pkg::MSEL_UPPER;
         end
      end else begin
         sel_in    = rmth_pkg::MSEL_MEAN;
         lo_cmd.op = rmth_pkg::HOP_PUSH;
         if (x > med_ff) begin
            lo_val    = up_top;
            up_cmd.op = rmth_pkg::HOP_REPLACE;
         end
      end
   end

   rmth_heap #(.DEPTH(DEPTH)) u_lower (
      .clock (clock),
      .reset (reset),
      .cmd   (lo_cmd),
      .value (lo_val),
      .busy  (lo_busy),
      .top   (lo_top),
      .size  (lo_size)
   );

   rmth_heap #(.DEPTH(DEPTH)) u_upper (
      .clock (clock),
      .reset (reset),
      .cmd   (up_cmd),
      .value (up_val),
      .busy  (up_busy),
      .top   (up_top),
      .size  (up_size)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmth_pkg::TS_IDLE: begin
            if (accept) begin
               state_in = full ? rmth_pkg::TS_DONE : rmth_pkg::TS_WAIT;
            end
         end
         rmth_pkg::TS_WAIT: begin
            if (!lo_busy && !up_busy) begin
               state_in = rmth_pkg::TS_DONE;
            end
         end
         rmth_pkg::TS_DONE: begin
            if (slot_free) begin
               state_in = rmth_pkg::TS_IDLE;
            end
         end
         default: state_in = rmth_pkg::TS_IDLE;
      endcase
   end

   // Outputs and result register
   always_comb begin
      req_tready   = (state_ff == rmth_pkg::TS_IDLE);
      drop_in      = accept ? full : drop_ff;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (state_ff == rmth_pkg::TS_DONE && slot_free) begin
         med_in       = med_pick;
         rsp_valid_in = 1'b1;
         rsp_data_in  = DATA_W'({count_now, med_pick});
         rsp_drop_in  = drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_drop_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmth_pkg::TS_IDLE;
         rsp_valid_ff <= 1'b0;
         med_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         med_ff       <= med_in;
      end
   end

   // Hold the item's routing and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff <= sel_in;
      end
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_drop_ff <= rsp_drop_in;
   end

`ifndef SYNTHESIS
   a_idle_heaps: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmth_pkg::TS_IDLE |-> !lo_busy && !up_busy)
      else $error("heap busy while unit idle");

   a_balance: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmth_pkg::TS_IDLE |->
         (lo_size <= up_size + S_W'(1)) && (up_size <= lo_size + S_W'(1)))
      else $error("heap sizes out of balance");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != rmth_pkg::TS_IDLE)
      else $error("transfer accepted without leaving idle");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_now <= CNT_W'(CAPACITY))
      else $error("held count beyond capacity");
`endif

endmodule

### rtl/rmth_heap.sv
// One binary heap in a synchronous memory with a sequential sift engine.
module rmth_heap #(
   parameter int DEPTH = 513
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmth_pkg::heap_cmd_type                cmd,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0]  value,
   output logic                                  busy,
   output logic signed [rmth_pkg::SAMPLE_W-1:0]  top,
   output logic [$clog2(DEPTH+1)-1:0]            size
);

   localparam int A_W = $clog2(DEPTH);
   localparam int C_W = A_W + 1;
   localparam int S_W = $clog2(DEPTH+1);

   logic signed [rmth_pkg::SAMPLE_W-1:0] mem [DEPTH];

   rmth_pkg::heap_state_type             state_ff, state_in;
   logic [A_W-1:0]                       idx_ff, idx_in;
   logic signed [rmth_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic [S_W-1:0]                       size_ff, size_in;
   logic signed [rmth_pkg::SAMPLE_W-1:0] top_ff, top_in;
   logic                                 max_ff, max_in;
   logic signed [rmth_pkg::SAMPLE_W-1:0] lval_ff, lval_in;
   logic signed [rmth_pkg::SAMPLE_W-1:0] rdata_ff;

   logic                                 we, re;
   logic [A_W-1:0]                       waddr, raddr;
   logic signed [rmth_pkg::SAMPLE_W-1:0] wdata;

   logic [C_W-1:0]                       lchild, rchild, size_c;
   logic [A_W-1:0]                       parent;
   logic                                 has_l, has_r, pick_r;
   logic signed [rmth_pkg::SAMPLE_W-1:0] cval;
   logic [A_W-1:0]                       cidx;
   logic [S_W-1:0]                       size_eff;

   // Tree neighbours of the hole
   assign lchild = {idx_ff, 1'b1};
   assign rchild = lchild + C_W'(1);
   assign size_c = C_W'(size_ff);
   assign parent = (idx_ff - A_W'(1)) >> 1;
   assign has_l  = lchild < size_c;
   assign has_r  = rchild < size_c;
   assign pick_r = has_r && rmth_pkg::above(max_ff, rdata_ff, lval_ff);
   assign cval   = pick_r ? rdata_ff : lval_ff;
   assign cidx   = pick_r ? rchild[A_W-1:0] : lchild[A_W-1:0];
   assign size_eff = cmd.flush ? '0 : size_ff;

   assign busy = (state_ff != rmth_pkg::HS_IDLE);
   assign top  = top_ff;
   assign size = size_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmth_pkg::HS_IDLE: begin
            if (cmd.start && cmd.op == rmth_pkg::HOP_PUSH) begin
               state_in = rmth_pkg::HS_UP_RD;
            end else if (cmd.start && cmd.op == rmth_pkg::HOP_REPLACE) begin
               state_in = rmth_pkg::HS_DN_RDL;
            end
         end
         rmth_pkg::HS_UP_RD: begin
            state_in = (idx_ff == '0) ? rmth_pkg::HS_IDLE : rmth_pkg::HS_UP_CMP;
         end
         rmth_pkg::HS_UP_CMP: begin
            state_in = rmth_pkg::above(max_ff, val_ff, rdata_ff) ?
                       rmth_pkg::HS_UP_RD : rmth_pkg::HS_IDLE;
         end
         rmth_pkg::HS_DN_RDL: begin
            state_in = has_l ? rmth_pkg::HS_DN_RDR : rmth_pkg::HS_IDLE;
         end
         rmth_pkg::HS_DN_RDR: begin
            state_in = rmth_pkg::HS_DN_CMP;
         end
         rmth_pkg::HS_DN_CMP: begin
            state_in = rmth_pkg::above(max_ff, cval, val_ff) ?
                       rmth_pkg::HS_DN_RDL : rmth_pkg::HS_IDLE;
         end
         default: state_in = rmth_pkg::HS_IDLE;
      endcase
   end

   // Datapath and memory port controls
   always_comb begin
      idx_in  = idx_ff;
      val_in  = val_ff;
      size_in = size_ff;
      top_in  = top_ff;
      max_in  = max_ff;
      lval_in = lval_ff;
      we      = 1'b0;
      waddr   = idx_ff;
      wdata   = val_ff;
      re      = 1'b0;
      raddr   = parent;
      unique case (state_ff)
         rmth_pkg::HS_IDLE: begin
            if (cmd.start) begin
               max_in  = cmd.max_mode;
               val_in  = value;
               size_in = size_eff;
               if (cmd.op == rmth_pkg::HOP_PUSH) begin
                  idx_in  = A_W'(size_eff);
                  size_in = size_eff + S_W'(1);
               end else if (cmd.op == rmth_pkg::HOP_REPLACE) begin
                  idx_in = '0;
               end
            end
         end
         rmth_pkg::HS_UP_RD: begin
            if (idx_ff == '0) begin
               we     = 1'b1;
               top_in = val_ff;
            end else begin
               re = 1'b1;
            end
         end
         rmth_pkg::HS_UP_CMP: begin
            we = 1'b1;
            if (rmth_pkg::above(max_ff, val_ff, rdata_ff)) begin
               // move the parent down into the hole
               wdata  = rdata_ff;
               idx_in = parent;
            end else if (idx_ff == '0) begin
               top_in = val_ff;
            end
         end
         rmth_pkg::HS_DN_RDL: begin
            if (has_l) begin
               re    = 1'b1;
               raddr = lchild[A_W-1:0];
            end else begin
               we = 1'b1;
               if (idx_ff == '0) begin
                  top_in = val_ff;
               end
            end
         end
         rmth_pkg::HS_DN_RDR: begin
            lval_in = rdata_ff;
            re      = has_r;
            raddr   = rchild[A_W-1:0];
         end
         rmth_pkg::HS_DN_CMP: begin
            we = 1'b1;
            if (rmth_pkg::above(max_ff, cval, val_ff)) begin
               // lift the better child into the hole
               wdata  = cval;
               idx_in = cidx;
               if (idx_ff == '0) begin
                  top_in = cval;
               end
            end else if (idx_ff == '0) begin
               top_in = val_ff;
            end
         end
         default: ;
      endcase
   end

   // Heap store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmth_pkg::HS_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      top_ff  <= top_in;
      max_ff  <= max_in;
      lval_ff <= lval_in;
   end

endmodule
